FILE: sv/rtnc_pkg.sv
// rtnc_pkg: shared widths, thresholds, palette codes and sideband type for
// the RGB to named colour classifier. No dependencies.
`timescale 1ns / 1ps

package rtnc_pkg;

  // default channel width
  localparam int CHANNEL_BITS_DEF = 8;

  // result field widths
  localparam int HUE_W    = 9;
  localparam int SAT_W    = 8;
  localparam int BRIGHT_W = 8;
  localparam int IDX_W    = 4;

  // quotient bits produced by every divider lane (one bit per stage)
  localparam int QUOT_W = 9;

  // arithmetic constants
  localparam int DEG_PER_SEXTANT = 60;
  localparam int SCALE           = 255;
  localparam int SAT_LIM         = 200;

  // gray thresholds on the 0..255 value scale
  localparam int WHITE_LIM = 212;
  localparam int GREY_LIM  = 127;
  localparam int DARK_LIM  = 85;

  // hue band edges in degrees
  localparam int HUE_RED_HI = 330;
  localparam int HUE_MAG    = 270;
  localparam int HUE_BLUE   = 210;
  localparam int HUE_CYAN   = 150;
  localparam int HUE_GREEN  = 90;
  localparam int HUE_YELLOW = 50;
  localparam int HUE_RED_LO = 20;

  typedef logic [IDX_W-1:0] color_idx_t;

  // palette codes
  localparam color_idx_t IDX_WHITE     = 4'd13;
  localparam color_idx_t IDX_GREY      = 4'd4;
  localparam color_idx_t IDX_DARK_GREY = 4'd5;
  localparam color_idx_t IDX_RED       = 4'd11;
  localparam color_idx_t IDX_MAGENTA   = 4'd10;
  localparam color_idx_t IDX_BLUE      = 4'd2;
  localparam color_idx_t IDX_CYAN      = 4'd3;
  localparam color_idx_t IDX_GREEN     = 4'd6;
  localparam color_idx_t IDX_YELLOW    = 4'd14;
  localparam color_idx_t IDX_ORANGE    = 4'd9;
  localparam color_idx_t IDX_DEFAULT   = 4'd13;

  // per-pixel flags and value carried alongside the dividers
  typedef struct packed {
    logic                gray;      // all channels equal
    logic                sat_hi;    // saturation above limit
    color_idx_t          gray_idx;  // palette code if gray
    logic [BRIGHT_W-1:0] bright;    // value on the 0..255 scale
  } side_t;

endpackage

FILE: sv/rtnc_front.sv
// rtnc_front: input register, max/min/delta stage and hue numerator stage.
// Depends on rtnc_pkg.
`timescale 1ns / 1ps

module rtnc_front #(
  parameter int CHANNEL_BITS = rtnc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic [CHANNEL_BITS-1:0] in_red,
  input  logic [CHANNEL_BITS-1:0] in_green,
  input  logic [CHANNEL_BITS-1:0] in_blue,
  output logic                    out_vld,
  output logic [CHANNEL_BITS+8:0] hue_dvd,
  output logic [CHANNEL_BITS-1:0] hue_dvs,
  output logic [CHANNEL_BITS+7:0] sat_dvd,
  output logic [CHANNEL_BITS-1:0] sat_dvs,
  output rtnc_pkg::side_t         side
);
  import rtnc_pkg::*;

  localparam int N    = CHANNEL_BITS;
  localparam int CMAX = (1 << N) - 1;

  localparam logic [N+7:0] SCALE_C = (N+8)'(SCALE);
  localparam logic [N+7:0] SATL_C  = (N+8)'(SAT_LIM);
  localparam logic [N+7:0] WHITE_C = (N+8)'(WHITE_LIM * CMAX);
  localparam logic [N+7:0] GREY_C  = (N+8)'(GREY_LIM * CMAX);
  localparam logic [N+7:0] DARK_C  = (N+8)'(DARK_LIM * CMAX);
  localparam logic [N+8:0] DEG_C   = (N+9)'(DEG_PER_SEXTANT);

  // value = mx * 255 / CMAX by reciprocal multiplication, exact for mx <= CMAX
  localparam int     S_BR  = 2 * N + 8;
  localparam longint BR_M  = ((longint'(1) << S_BR) + longint'(CMAX) - 1) / longint'(CMAX);
  localparam int     BRP_W = 2 * N + 17;
  localparam logic [BRP_W-1:0] BR_K = BRP_W'(BR_M * SCALE);

  typedef enum logic [1:0] {MAX_R, MAX_G, MAX_B} max_sel_t;

  // stage A: input word
  logic         a_vld_r;
  logic [N-1:0] a_r_r, a_g_r, a_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
    a_r_r <= in_red;
    a_g_r <= in_green;
    a_b_r <= in_blue;
  end

  // stage B: max channel (ties red, green, blue), delta, signed difference
  max_sel_t       b_sel_nxt, b_sel_r;
  logic [N-1:0]   b_mx_nxt, b_mn_nxt, b_mx_r, b_dl_r;
  logic signed [N:0] b_diff_nxt, b_diff_r;
  logic           b_vld_r;

  always_comb begin
    if (a_r_r >= a_g_r && a_r_r >= a_b_r) begin
      b_sel_nxt  = MAX_R;
      b_mx_nxt   = a_r_r;
      b_diff_nxt = $signed({1'b0, a_g_r}) - $signed({1'b0, a_b_r});
    end else if (a_g_r >= a_b_r) begin
      b_sel_nxt  = MAX_G;
      b_mx_nxt   = a_g_r;
      b_diff_nxt = $signed({1'b0, a_b_r}) - $signed({1'b0, a_r_r});
    end else begin
      b_sel_nxt  = MAX_B;
      b_mx_nxt   = a_b_r;
      b_diff_nxt = $signed({1'b0, a_r_r}) - $signed({1'b0, a_g_r});
    end
    if (a_r_r <= a_g_r && a_r_r <= a_b_r) begin
      b_mn_nxt = a_r_r;
    end else if (a_g_r <= a_b_r) begin
      b_mn_nxt = a_g_r;
    end else begin
      b_mn_nxt = a_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_sel_r  <= b_sel_nxt;
    b_mx_r   <= b_mx_nxt;
    b_dl_r   <= b_mx_nxt - b_mn_nxt;
    b_diff_r <= b_diff_nxt;
  end

  // stage C: sextant base, hue numerator 60*t, scaled terms, value and flags
  logic [N+2:0]        base;
  logic signed [N+3:0] t_s;
  logic [N+2:0]        t;
  logic [N+7:0]        mx_x255, dl_x255, mx_x200;
  logic [BRP_W-1:0]    br_prod;
  side_t               side_nxt;

  always_comb begin
    case (b_sel_r)
      MAX_R:   base = b_diff_r[N] ? (((N+3)'(b_dl_r) << 2) + ((N+3)'(b_dl_r) << 1))
                                  : '0;
      MAX_G:   base = (N+3)'(b_dl_r) << 1;
      MAX_B:   base = (N+3)'(b_dl_r) << 2;
      default: base = '0;
    endcase
    t_s     = $signed({1'b0, base}) + $signed({{3{b_diff_r[N]}}, b_diff_r});
    t       = t_s[N+2:0];
    mx_x255 = (N+8)'(b_mx_r) * SCALE_C;
    dl_x255 = (N+8)'(b_dl_r) * SCALE_C;
    mx_x200 = (N+8)'(b_mx_r) * SATL_C;
    br_prod = BRP_W'(b_mx_r) * BR_K;

    side_nxt.gray   = (b_dl_r == '0);
    side_nxt.sat_hi = (dl_x255 > mx_x200);
    side_nxt.bright = br_prod[S_BR +: BRIGHT_W];
    if (mx_x255 > WHITE_C) begin
      side_nxt.gray_idx = IDX_WHITE;
    end else if (mx_x255 > GREY_C) begin
      side_nxt.gray_idx = IDX_GREY;
    end else if (mx_x255 > DARK_C) begin
      side_nxt.gray_idx = IDX_DARK_GREY;
    end else begin
      side_nxt.gray_idx = IDX_DEFAULT;
    end
  end

  logic         c_vld_r;
  logic [N+8:0] c_hn_r;
  logic [N-1:0] c_dl_r, c_mx_r;
  logic [N+7:0] c_sat_dvd_r;
  side_t        c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
    c_hn_r      <= (N+9)'(t) * DEG_C;
    c_dl_r      <= b_dl_r;
    c_mx_r      <= b_mx_r;
    c_sat_dvd_r <= dl_x255;
    c_side_r    <= side_nxt;
  end

  assign out_vld = c_vld_r;
  assign hue_dvd = c_hn_r;
  assign hue_dvs = c_dl_r;
  assign sat_dvd = c_sat_dvd_r;
  assign sat_dvs = c_mx_r;
  assign side    = c_side_r;

endmodule

FILE: sv/rtnc_div_pipe.sv
// rtnc_div_pipe: two restoring divider lanes (hue, saturation),
// one quotient bit per register stage. Depends on rtnc_pkg.
`timescale 1ns / 1ps

module rtnc_div_pipe #(
  parameter int CHANNEL_BITS = rtnc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic [CHANNEL_BITS+8:0]        hue_dvd,
  input  logic [CHANNEL_BITS-1:0]        hue_dvs,
  input  logic [CHANNEL_BITS+7:0]        sat_dvd,
  input  logic [CHANNEL_BITS-1:0]        sat_dvs,
  input  rtnc_pkg::side_t                in_side,
  output logic                           out_vld,
  output logic [rtnc_pkg::QUOT_W-1:0]    hue_q,
  output logic                           hue_rem_nz,
  output logic [rtnc_pkg::QUOT_W-1:0]    sat_q,
  output rtnc_pkg::side_t                out_side
);
  import rtnc_pkg::*;

  localparam int N     = CHANNEL_BITS;
  localparam int W     = N + 9;
  localparam int QW    = QUOT_W;
  localparam int LANES = 2;
  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;

  // per stage, per lane registers
  logic [W-1:0]  rem_r [QW][LANES];
  logic [N-1:0]  dvs_r [QW][LANES];
  logic [QW-1:0] q_r   [QW][LANES];
  logic          vld_r [QW];
  side_t         side_r[QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;

    logic [W-1:0]  rem_in [LANES];
    logic [N-1:0]  dvs_in [LANES];
    logic [QW-1:0] q_in   [LANES];
    logic          vld_in;
    side_t         side_in;
    logic [W-1:0]  rem_nxt[LANES];
    logic [QW-1:0] q_nxt  [LANES];

    // stage input: front-end word or previous stage
    if (k == 0) begin : g_first
      always_comb begin
        rem_in[LANE_HUE] = hue_dvd;
        rem_in[LANE_SAT] = W'(sat_dvd);
        dvs_in[LANE_HUE] = hue_dvs;
        dvs_in[LANE_SAT] = sat_dvs;
        for (int l = 0; l < LANES; l++) begin
          q_in[l] = '0;
        end
        vld_in  = in_vld;
        side_in = in_side;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = rem_r[k-1][l];
          dvs_in[l] = dvs_r[k-1][l];
          q_in[l]   = q_r[k-1][l];
        end
        vld_in  = vld_r[k-1];
        side_in = side_r[k-1];
      end
    end

    // one restoring step: trial subtract of divisor << SH
    always_comb begin
      logic [W-1:0] trial;
      for (int l = 0; l < LANES; l++) begin
        trial = W'(dvs_in[l]) << SH;
        if (rem_in[l] >= trial) begin
          rem_nxt[l] = rem_in[l] - trial;
          q_nxt[l]   = {q_in[l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = rem_in[l];
          q_nxt[l]   = {q_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
      for (int l = 0; l < LANES; l++) begin
        rem_r[k][l] <= rem_nxt[l];
        dvs_r[k][l] <= dvs_in[l];
        q_r[k][l]   <= q_nxt[l];
      end
      side_r[k] <= side_in;
    end
  end

  assign out_vld    = vld_r[QW-1];
  assign hue_q      = q_r[QW-1][LANE_HUE];
  assign hue_rem_nz = |rem_r[QW-1][LANE_HUE];
  assign sat_q      = q_r[QW-1][LANE_SAT];
  assign out_side   = side_r[QW-1];

endmodule

FILE: sv/rtnc_classify.sv
// rtnc_classify: hue band and gray decision, output register stage.
// Depends on rtnc_pkg.
`timescale 1ns / 1ps

module rtnc_classify (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic [rtnc_pkg::QUOT_W-1:0]     hue_q,
  input  logic                            hue_rem_nz,
  input  logic [rtnc_pkg::QUOT_W-1:0]     sat_q,
  input  rtnc_pkg::side_t                 side,
  output logic                            out_valid,
  output logic [rtnc_pkg::HUE_W-1:0]      out_hue_degrees,
  output logic [rtnc_pkg::SAT_W-1:0]      out_saturation,
  output logic [rtnc_pkg::BRIGHT_W-1:0]   out_brightness,
  output rtnc_pkg::color_idx_t            out_color_index
);
  import rtnc_pkg::*;

  // exact hue > limit from quotient and remainder
  function automatic logic hue_above(input logic [QUOT_W-1:0] q, input logic rnz,
                                     input int limit);
    logic [QUOT_W-1:0] lim;
    lim = QUOT_W'(limit);
    return (q > lim) || ((q == lim) && rnz);
  endfunction

  color_idx_t idx_nxt;

  always_comb begin
    if (side.gray) begin
      idx_nxt = side.gray_idx;
    end else if (side.sat_hi) begin
      if (hue_above(hue_q, hue_rem_nz, HUE_RED_HI) ||
          !hue_above(hue_q, hue_rem_nz, HUE_RED_LO)) begin
        idx_nxt = IDX_RED;
      end else if (hue_above(hue_q, hue_rem_nz, HUE_MAG)) begin
        idx_nxt = IDX_MAGENTA;
      end else if (hue_above(hue_q, hue_rem_nz, HUE_BLUE)) begin
        idx_nxt = IDX_BLUE;
      end else if (hue_above(hue_q, hue_rem_nz, HUE_CYAN)) begin
        idx_nxt = IDX_CYAN;
      end else if (hue_above(hue_q, hue_rem_nz, HUE_GREEN)) begin
        idx_nxt = IDX_GREEN;
      end else if (hue_above(hue_q, hue_rem_nz, HUE_YELLOW)) begin
        idx_nxt = IDX_YELLOW;
      end else begin
        idx_nxt = IDX_ORANGE;
      end
    end else begin
      idx_nxt = IDX_DEFAULT;
    end
  end

  // result word register; gray pixels report zero hue and saturation
  logic                valid_r;
  logic [HUE_W-1:0]    hue_r;
  logic [SAT_W-1:0]    sat_r;
  logic [BRIGHT_W-1:0] br_r;
  color_idx_t          idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_vld;
    end
    hue_r <= side.gray ? '0 : HUE_W'(hue_q);
    sat_r <= side.gray ? '0 : sat_q[SAT_W-1:0];
    br_r  <= side.bright;
    idx_r <= idx_nxt;
  end

  assign out_valid       = valid_r;
  assign out_hue_degrees = hue_r;
  assign out_saturation  = sat_r;
  assign out_brightness  = br_r;
  assign out_color_index = idx_r;

endmodule

FILE: sv/rgb_to_named_color_classifier.sv
// rgb_to_named_color_classifier: top level, RGB pixel to HSV and palette index.
// Depends on rtnc_pkg, rtnc_front, rtnc_div_pipe, rtnc_classify.
`timescale 1ns / 1ps
//
//  Channel | Ports                                         | Handshake
//  --------+-----------------------------------------------+---------------------------
//  input   | in_red, in_green, in_blue                     | taken when start && !busy
//  result  | out_hue_degrees, out_saturation,              | out_valid strobe, 1 cycle
//          | out_brightness, out_color_index               |
//
//  One pixel word accepted every clock while start is high and busy is low;
//  the result strobes once the word has passed all registers in order
//  (3 front-end stages, 9 divider stages at one quotient bit each,
//  1 output register). Sync reset clears all valid bits; busy is high only
//  while reset is applied and for the cycle after it. The result cannot be
//  held off, so nothing in the pipe ever stalls.

module rgb_to_named_color_classifier #(
  parameter int CHANNEL_BITS = rtnc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [CHANNEL_BITS-1:0]         in_red,
  input  logic [CHANNEL_BITS-1:0]         in_green,
  input  logic [CHANNEL_BITS-1:0]         in_blue,
  output logic                            out_valid,
  output logic [rtnc_pkg::HUE_W-1:0]      out_hue_degrees,
  output logic [rtnc_pkg::SAT_W-1:0]      out_saturation,
  output logic [rtnc_pkg::BRIGHT_W-1:0]   out_brightness,
  output rtnc_pkg::color_idx_t            out_color_index
);
  import rtnc_pkg::*;

  localparam int N = CHANNEL_BITS;

  // busy only around reset
  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  logic accept;
  assign accept = start && !busy_r;

  // front end
  logic         fe_vld;
  logic [N+8:0] hue_dvd;
  logic [N-1:0] hue_dvs, sat_dvs;
  logic [N+7:0] sat_dvd;
  side_t        fe_side;

  rtnc_front #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .in_red  (in_red),
    .in_green(in_green),
    .in_blue (in_blue),
    .out_vld (fe_vld),
    .hue_dvd (hue_dvd),
    .hue_dvs (hue_dvs),
    .sat_dvd (sat_dvd),
    .sat_dvs (sat_dvs),
    .side    (fe_side)
  );

  // divider lanes
  logic              dv_vld;
  logic [QUOT_W-1:0] hue_q, sat_q;
  logic              hue_rem_nz;
  side_t             dv_side;

  rtnc_div_pipe #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (fe_vld),
    .hue_dvd   (hue_dvd),
    .hue_dvs   (hue_dvs),
    .sat_dvd   (sat_dvd),
    .sat_dvs   (sat_dvs),
    .in_side   (fe_side),
    .out_vld   (dv_vld),
    .hue_q     (hue_q),
    .hue_rem_nz(hue_rem_nz),
    .sat_q     (sat_q),
    .out_side  (dv_side)
  );

  // classification and result register
  rtnc_classify u_class (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vld         (dv_vld),
    .hue_q          (hue_q),
    .hue_rem_nz     (hue_rem_nz),
    .sat_q          (sat_q),
    .side           (dv_side),
    .out_valid      (out_valid),
    .out_hue_degrees(out_hue_degrees),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .out_color_index(out_color_index)
  );

endmodule

FILE: dv/tb_top.sv
// tb_top: self-checking bench for rgb_to_named_color_classifier. It drives random and
// corner-case pixel words, predicts HSV and palette index, and checks each result word.
// Depends on rtnc_pkg and the rgb_to_named_color_classifier RTL.
`timescale 1ns / 1ps

module tb_top;
  import rtnc_pkg::*;

  localparam int CH_BITS    = CHANNEL_BITS_DEF;
  localparam int CMAX       = (1 << CH_BITS) - 1;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  // one result word as the block presents it
  typedef struct packed {
    logic [HUE_W-1:0]    hue;
    logic [SAT_W-1:0]    sat;
    logic [BRIGHT_W-1:0] bright;
    color_idx_t          idx;
  } hsv_word_t;

  // predicts each pixel's HSV word and checks results in arrival order
  class pixel_scoreboard;
    hsv_word_t hsv_expected_q[$];
    int        mismatch_cnt;

    function hsv_word_t classify_pixel(logic [CH_BITS-1:0] r8, logic [CH_BITS-1:0] g8,
                                       logic [CH_BITS-1:0] b8);
      int        r, g, b, mx, mn, dl, t, hn;
      hsv_word_t res;
      r = int'(r8);
      g = int'(g8);
      b = int'(b8);
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      dl = mx - mn;
      hn = 0;
      res.hue = '0;
      res.sat = '0;
      res.bright = BRIGHT_W'((mx * SCALE / CMAX > 255) ? 255 : mx * SCALE / CMAX);
      res.idx = IDX_DEFAULT;
      // hue scaled by delta; ties go red, then green, then blue
      if (dl != 0) begin
        if (r == mx) begin
          t = g - b;
          if (t < 0) t += 6 * dl;
        end else if (g == mx) begin
          t = 2 * dl + b - r;
        end else begin
          t = 4 * dl + r - g;
        end
        if (t < 0) t = 0;
        hn = DEG_PER_SEXTANT * t;
        res.hue = HUE_W'((hn / dl > 359) ? 359 : hn / dl);
        res.sat = SAT_W'(dl * SCALE / mx);
      end
      // palette: gray split by value, saturated split by hue band (exact compares)
      if (dl == 0) begin
        if (mx * SCALE > WHITE_LIM * CMAX) res.idx = IDX_WHITE;
        else if (mx * SCALE > GREY_LIM * CMAX) res.idx = IDX_GREY;
        else if (mx * SCALE > DARK_LIM * CMAX) res.idx = IDX_DARK_GREY;
      end else if (dl * SCALE > SAT_LIM * mx) begin
        if (hn > HUE_RED_HI * dl || hn <= HUE_RED_LO * dl) res.idx = IDX_RED;
        else if (hn > HUE_MAG * dl) res.idx = IDX_MAGENTA;
        else if (hn > HUE_BLUE * dl) res.idx = IDX_BLUE;
        else if (hn > HUE_CYAN * dl) res.idx = IDX_CYAN;
        else if (hn > HUE_GREEN * dl) res.idx = IDX_GREEN;
        else if (hn > HUE_YELLOW * dl) res.idx = IDX_YELLOW;
        else res.idx = IDX_ORANGE;
      end
      return res;
    endfunction

    function void note_pixel(logic [CH_BITS-1:0] r, logic [CH_BITS-1:0] g,
                             logic [CH_BITS-1:0] b);
      hsv_expected_q.push_back(classify_pixel(r, g, b));
    endfunction

    function int pending();
      return hsv_expected_q.size();
    endfunction

    function void flag(string what, hsv_word_t want, hsv_word_t got);
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t %s: exp hue %0d sat %0d bright %0d idx %0d, %s %0d %s %0d %s %0d %s %0d",
                 $realtime, what, want.hue, want.sat, want.bright, want.idx,
                 "got hue", got.hue, "sat", got.sat, "bright", got.bright,
                 "idx", got.idx);
    endfunction

    function void check_result(hsv_word_t got);
      hsv_word_t want;
      if (hsv_expected_q.size() == 0) begin
        want = '0;
        flag("result word with none pending", want, got);
      end else begin
        want = hsv_expected_q.pop_front();
        if (got.hue !== want.hue || got.sat !== want.sat ||
            got.bright !== want.bright || got.idx !== want.idx)
          flag("result word mismatch", want, got);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [CH_BITS-1:0]    in_red, in_green, in_blue;
  logic                  out_valid;
  logic [HUE_W-1:0]      out_hue_degrees;
  logic [SAT_W-1:0]      out_saturation;
  logic [BRIGHT_W-1:0]   out_brightness;
  color_idx_t            out_color_index;

  logic                  pixel_taken = 1'b0;
  int                    stall_cycles = 0;
  pixel_scoreboard       hsv_sb = new();

  rgb_to_named_color_classifier #(.CHANNEL_BITS(CH_BITS)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_hue_degrees (out_hue_degrees),
    .out_saturation  (out_saturation),
    .out_brightness  (out_brightness),
    .out_color_index (out_color_index)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin : monitor
    hsv_word_t got;
    pixel_taken = rst_n && start && !busy;
    if (pixel_taken) hsv_sb.note_pixel(in_red, in_green, in_blue);
    if (rst_n && out_valid) begin
      got.hue    = out_hue_degrees;
      got.sat    = out_saturation;
      got.bright = out_brightness;
      got.idx    = out_color_index;
      hsv_sb.check_result(got);
    end
    if (pixel_taken || (rst_n && out_valid)) stall_cycles = 0;
    else stall_cycles++;
  end

  // watchdog: too long without any word moving
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("rgb_to_named_color_classifier test failed");
    $finish;
  end

  // present one pixel word from a falling edge and hold it until taken
  task automatic send_pixel(input logic [CH_BITS-1:0] r, input logic [CH_BITS-1:0] g,
                            input logic [CH_BITS-1:0] b);
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do begin
      @(posedge clk);
      @(negedge clk);
    end while (!pixel_taken);
  endtask

  // sender gap, with junk on the data ports
  task automatic idle_cycles(input int n);
    start    <= 1'b0;
    in_red   <= CH_BITS'($urandom);
    in_green <= CH_BITS'($urandom);
    in_blue  <= CH_BITS'($urandom);
    repeat (n) @(negedge clk);
  endtask

  // hold off until every pending result word has come back
  task automatic wait_for_drain();
    start <= 1'b0;
    while (hsv_sb.pending() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [CH_BITS-1:0] ch[3];
    logic [CH_BITS-1:0] tmp;
    int                 mode, j, k, pct, phase, n, hi_v, lo_v, base;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_red   = '0;
    in_green = '0;
    in_blue  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: gray thresholds, primaries, band edges, saturation limit
    send_pixel(8'd0, 8'd0, 8'd0);        // black
    send_pixel(8'd255, 8'd255, 8'd255);  // full white
    send_pixel(8'd213, 8'd213, 8'd213);  // just above white limit
    send_pixel(8'd212, 8'd212, 8'd212);  // on white limit -> grey
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd127, 8'd127, 8'd127);  // on grey limit -> dark grey
    send_pixel(8'd86, 8'd86, 8'd86);
    send_pixel(8'd85, 8'd85, 8'd85);     // dim gray keeps default
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);    // green/blue tie
    send_pixel(8'd255, 8'd0, 8'd255);    // red/blue tie
    send_pixel(8'd255, 8'd255, 8'd0);    // red/green tie
    send_pixel(8'd255, 8'd128, 8'd0);    // orange
    send_pixel(8'd255, 8'd0, 8'd10);     // red with hue wrapping past 350
    send_pixel(8'd2, 8'd0, 8'd1);        // hue exactly 330
    send_pixel(8'd3, 8'd1, 8'd0);        // hue exactly 20
    send_pixel(8'd6, 8'd5, 8'd0);        // hue exactly 50
    send_pixel(8'd255, 8'd55, 8'd55);    // saturation on the limit
    send_pixel(8'd255, 8'd54, 8'd54);    // saturation just over
    send_pixel(8'd200, 8'd100, 8'd150);  // weak colour
    send_pixel(8'd1, 8'd0, 8'd0);        // smallest colour
    send_pixel(8'd255, 8'd254, 8'd255);
    wait_for_drain();

    // random phases: sender idles 18 %, then 78 %, then not at all
    for (phase = 0; phase < 3; phase++) begin
      pct = (phase == 0) ? 18 : (phase == 1) ? 78 : 0;
      for (n = 0; n < 400; n++) begin
        // idling once per successful draw keeps the idle share of cycles at pct
        while ($urandom_range(0, 99) < pct) idle_cycles(1);
        mode = $urandom_range(0, 9);
        case (mode)
          3: begin  // gray
            ch[0] = CH_BITS'($urandom);
            ch[1] = ch[0];
            ch[2] = ch[0];
          end
          4, 5, 6: begin  // strongly saturated
            hi_v  = $urandom_range(40, CMAX);
            lo_v  = $urandom_range(0, hi_v / 5);
            ch[0] = CH_BITS'(hi_v);
            ch[1] = CH_BITS'($urandom_range(lo_v, hi_v));
            ch[2] = CH_BITS'(lo_v);
          end
          7: begin  // near gray
            base = $urandom_range(0, CMAX - 3);
            for (j = 0; j < 3; j++) ch[j] = CH_BITS'(base + $urandom_range(0, 3));
          end
          8: for (j = 0; j < 3; j++) ch[j] = CH_BITS'($urandom_range(0, 15));
          9: begin  // two channels tied
            ch[0] = CH_BITS'($urandom);
            ch[1] = ch[0];
            ch[2] = CH_BITS'($urandom);
          end
          default: for (j = 0; j < 3; j++) ch[j] = CH_BITS'($urandom);
        endcase
        for (j = 2; j > 0; j--) begin
          k     = $urandom_range(0, j);
          tmp   = ch[j];
          ch[j] = ch[k];
          ch[k] = tmp;
        end
        send_pixel(ch[0], ch[1], ch[2]);
      end
      if (phase == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (hsv_sb.mismatch_cnt == 0 && hsv_sb.pending() == 0)
      $display("rgb_to_named_color_classifier test passed");
    else
      $display("rgb_to_named_color_classifier test failed");
    $finish;
  end

endmodule
